/* sv/gwie_pkg.sv */
// Package for the grid window ID enumerator: field widths, payload structs,
// register indexes and the sequencer's microcode table. No dependencies.
package gwie_pkg;

  localparam int ID_W          = 17;
  localparam int RAD_W         = 2;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int DIV_CNT_W     = 5;
  localparam int STEP_W        = 3;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_SIDE   = 256;
  localparam int RESET_SIDE     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;

  typedef struct packed {
    logic [ID_W-1:0]  center_id;
    logic [RAD_W-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] point_id;
    logic            last_point;
    logic            bad_center;
  } out_item_t;

  // Program steps.
  localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DIV   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_EDGES = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_BAD   = 3'd5;

  // Jump conditions.
  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_START    = 3'd2;
  localparam logic [2:0] COND_BAD      = 3'd3;
  localparam logic [2:0] COND_DIV_DONE = 3'd4;
  localparam logic [2:0] COND_LAST     = 3'd5;

  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              hold;       // repeat this step while the condition is false
    logic              load_in;
    logic              div_init;
    logic              div_step;
    logic              edges_calc;
    logic              emit;
    logic              emit_bad;
  } ucode_t;

  // On a true condition the step counter jumps to target; otherwise it holds
  // or advances by one, as the hold bit says.
  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_WAIT: begin
        w.cond = COND_START; w.target = STEP_CHECK; w.hold = 1'b1; w.load_in = 1'b1;
      end
      STEP_CHECK: begin
        w.cond = COND_BAD; w.target = STEP_BAD; w.div_init = 1'b1;
      end
      STEP_DIV: begin
        w.cond = COND_DIV_DONE; w.target = STEP_EDGES; w.hold = 1'b1; w.div_step = 1'b1;
      end
      STEP_EDGES: begin
        w.cond = COND_NEVER; w.edges_calc = 1'b1;
      end
      STEP_EMIT: begin
        w.cond = COND_LAST; w.target = STEP_WAIT; w.hold = 1'b1; w.emit = 1'b1;
      end
      STEP_BAD: begin
        w.cond = COND_ALWAYS; w.target = STEP_WAIT; w.emit_bad = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS; w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/grid_window_id_enumerator_unit.sv */
// Grid window ID enumerator: a microcoded sequencer that divides the center ID
// by the column count, clips the window per axis and emits the window's IDs.
// Depends on gwie_pkg.
//
//   channel  ports                            transaction at the clock edge where
//   input    start, busy, in_payload          start is high and busy is low
//   result   out_strobe, out_payload          out_strobe is high (cannot stall)
//   config   cfg_we, cfg_index, cfg_wdata     cfg_we is high
//
// A valid center passes through one check step, the steps of the bit-serial divider that
// split the ID into row and column, one clipping step, then one result per cycle, one for
// each window point (at most 49). A bad center gives one result. A new center is
// accepted only once the sequencer is back in its wait step.
// Reset sets both grid sides to 16 and returns the sequencer to its wait step.
// Results leave through an output register; nothing downstream can hold them.
module grid_window_id_enumerator_unit
  import gwie_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int MAX_SIDE   = DEF_MAX_SIDE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_payload,
  output logic                 out_strobe,
  output out_item_t            out_payload,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_SIDE + 1);
  localparam int PW = 2 * CW;
  localparam int TW = (PW > ID_W) ? PW : ID_W;
  localparam logic [TW-1:0] TOTAL_RESET = TW'(RESET_SIDE * RESET_SIDE);

  logic [CFG_W-1:0]     cols_r, rows_r;
  logic [CW-1:0]        cols_c, rows_c;
  logic [TW-1:0]        total_r;

  logic [STEP_W-1:0]    step_r, step_nxt;
  ucode_t               uc;
  logic                 cond_true;

  logic [ID_W-1:0]      id_r;
  logic [RAD_W-1:0]     rad_r;
  logic [ID_W-1:0]      quo_r, quo_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CW:0]          div_trial;
  logic                 div_ge;

  logic [CW-1:0]        x_r, x0_r, x1_r, y_r, y1_r;
  logic [PW-1:0]        base_r;
  logic [CW:0]          rad_e, col_e, row_e, lim_c, lim_r, col_top, row_top;
  logic [CW-1:0]        x0_c, x1_c, y0_c, y1_c;
  logic                 bad_c, last_c;

  logic                 out_strobe_r, out_strobe_nxt;
  out_item_t            out_payload_r, out_payload_nxt;

  // A side of zero counts as one; a side above MAX_SIDE is cut to MAX_SIDE.
  always_comb begin
    if (cols_r == '0) begin
      cols_c = CW'(1);
    end else if (32'(cols_r) > MAX_SIDE) begin
      cols_c = CW'(MAX_SIDE);
    end else begin
      cols_c = CW'(cols_r);
    end
    if (rows_r == '0) begin
      rows_c = CW'(1);
    end else if (32'(rows_r) > MAX_SIDE) begin
      rows_c = CW'(MAX_SIDE);
    end else begin
      rows_c = CW'(rows_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= CFG_W'(RESET_SIDE);
      rows_r  <= CFG_W'(RESET_SIDE);
      total_r <= TOTAL_RESET;
    end else begin
      if (cfg_we && cfg_index == REG_GRID_COLUMNS) begin
        cols_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_GRID_ROWS) begin
        rows_r <= cfg_wdata;
      end
      total_r <= TW'(cols_c) * TW'(rows_c);
    end
  end

  assign uc     = ucode_word(step_r);
  assign busy   = (step_r != STEP_WAIT);
  assign bad_c  = (id_r == '0) || (TW'(id_r) > total_r);
  assign last_c = (x_r == x1_r) && (y_r == y1_r);

  always_comb begin
    case (uc.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_START:    cond_true = start;
      COND_BAD:      cond_true = bad_c;
      COND_DIV_DONE: cond_true = (div_cnt_r == '0);
      COND_LAST:     cond_true = last_c;
      default:       cond_true = 1'b0;
    endcase
    if (cond_true) begin
      step_nxt = uc.target;
    end else if (uc.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  // Restoring divider, one quotient bit per step; the dividend shifts out of
  // quo_r from the top while quotient bits enter at the bottom.
  assign div_trial = {rem_r, quo_r[ID_W-1]};
  assign div_ge    = (div_trial >= {1'b0, cols_c});

  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    if (uc.div_init) begin
      quo_nxt     = id_r - ID_W'(1);
      rem_nxt     = '0;
      div_cnt_nxt = DIV_CNT_W'(ID_W - 1);
    end else if (uc.div_step) begin
      quo_nxt     = {quo_r[ID_W-2:0], div_ge};
      rem_nxt     = div_ge ? CW'(div_trial - {1'b0, cols_c}) : CW'(div_trial);
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end
  end

  // Per-axis clipping: the window is cut at both grid edges independently.
  always_comb begin
    rad_e   = (CW + 1)'(rad_r);
    col_e   = {1'b0, rem_r};
    row_e   = {1'b0, quo_r[CW-1:0]};
    lim_c   = {1'b0, cols_c} - (CW + 1)'(1);
    lim_r   = {1'b0, rows_c} - (CW + 1)'(1);
    col_top = col_e + rad_e;
    row_top = row_e + rad_e;
    x0_c    = (col_e >= rad_e) ? CW'(col_e - rad_e) : '0;
    y0_c    = (row_e >= rad_e) ? CW'(row_e - rad_e) : '0;
    x1_c    = (col_top > lim_c) ? CW'(lim_c) : CW'(col_top);
    y1_c    = (row_top > lim_r) ? CW'(lim_r) : CW'(row_top);
  end

  always_comb begin
    out_strobe_nxt  = 1'b0;
    out_payload_nxt = out_payload_r;
    if (uc.emit) begin
      out_strobe_nxt             = 1'b1;
      out_payload_nxt.point_id   = ID_W'(base_r + PW'(x_r) + PW'(1));
      out_payload_nxt.last_point = last_c;
      out_payload_nxt.bad_center = 1'b0;
    end else if (uc.emit_bad) begin
      out_strobe_nxt             = 1'b1;
      out_payload_nxt.point_id   = '0;
      out_payload_nxt.last_point = 1'b1;
      out_payload_nxt.bad_center = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= STEP_WAIT;
      out_strobe_r <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_payload_r <= out_payload_nxt;
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    div_cnt_r     <= div_cnt_nxt;
    if (uc.load_in && start) begin
      id_r  <= in_payload.center_id;
      rad_r <= (32'(in_payload.radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                     : in_payload.radius;
    end
    if (uc.edges_calc) begin
      x0_r   <= x0_c;
      x1_r   <= x1_c;
      y1_r   <= y1_c;
      x_r    <= x0_c;
      y_r    <= y0_c;
      base_r <= PW'(y0_c) * PW'(cols_c);
    end else if (uc.emit) begin
      if (x_r == x1_r) begin
        x_r    <= x0_r;
        y_r    <= y_r + CW'(1);
        base_r <= base_r + PW'(cols_c);
      end else begin
        x_r <= x_r + CW'(1);
      end
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_payload_r;

endmodule
